[rtl/kpd_pkg.sv]
// package for the keypad code prefix dictionary
// shared widths, status codes, scan structs and keypad coding functions
// no dependencies
`timescale 1ns / 1ps

package kpd_pkg;

   localparam int DEFAULT_ENTRIES  = 64;
   localparam int DEFAULT_WORD_LEN = 19;

   localparam int MATCH_W  = 6;
   localparam int SYMBOL_W = 8;
   localparam int DIGIT_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // query digit code that no stored digit can equal
   localparam logic [DIGIT_W-1:0] DIGIT_NONE = 4'hf;
   localparam logic [SYMBOL_W-1:0] MAX_QUERY_DIGIT = 8'd9;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_WORD_LONG  = 2'd2,
      STATUS_QUERY_LONG = 2'd3
   } status_type;

   // read issued to the code memory, travels with the read data
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [MATCH_W-1:0] entry;
   } scan_tag_type;

   // compare outcome for one entry
   typedef struct packed {
      logic               valid;
      logic               last;
      logic               hit;
      logic [MATCH_W-1:0] entry;
   } match_type;

   // lower-case letters to phone keypad digits, anything else 0
   function automatic logic [DIGIT_W-1:0] key_of(input logic [SYMBOL_W-1:0] ch);
      logic [DIGIT_W-1:0] key;
      key = '0;
      if (ch >= 8'h61 && ch <= 8'h63) key = 4'd2;
      if (ch >= 8'h64 && ch <= 8'h66) key = 4'd3;
      if (ch >= 8'h67 && ch <= 8'h69) key = 4'd4;
      if (ch >= 8'h6a && ch <= 8'h6c) key = 4'd5;
      if (ch >= 8'h6d && ch <= 8'h6f) key = 4'd6;
      if (ch >= 8'h70 && ch <= 8'h73) key = 4'd7;
      if (ch >= 8'h74 && ch <= 8'h76) key = 4'd8;
      if (ch >= 8'h77 && ch <= 8'h7a) key = 4'd9;
      return key;
   endfunction

   function automatic logic [DIGIT_W-1:0] query_digit(input logic [SYMBOL_W-1:0] sym);
      logic [DIGIT_W-1:0] digit;
      digit = (sym > MAX_QUERY_DIGIT) ? DIGIT_NONE : sym[DIGIT_W-1:0];
      return digit;
   endfunction

endpackage

[rtl/kpd_code_mem.sv]
// code memory: one row per entry holding its digit string and its length
// digit-masked write port, one registered read port; uses kpd_pkg
`timescale 1ns / 1ps

module kpd_code_mem #(
   parameter int ENTRIES  = kpd_pkg::DEFAULT_ENTRIES,
   parameter int WORD_LEN = kpd_pkg::DEFAULT_WORD_LEN,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int POS_W   = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1,
   localparam int LEN_W   = $clog2(WORD_LEN + 1)
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [IDX_W-1:0]                           wr_addr,
   input  logic [POS_W-1:0]                           wr_pos,
   input  logic [kpd_pkg::DIGIT_W-1:0]                wr_digit,
   input  logic                                       len_en,
   input  logic [LEN_W-1:0]                           wr_len,
   input  logic                                       rd_en,
   input  logic [IDX_W-1:0]                           rd_addr,
   output logic [WORD_LEN-1:0][kpd_pkg::DIGIT_W-1:0]  rd_digits,
   output logic [LEN_W-1:0]                           rd_len
);
   import kpd_pkg::*;

   logic [WORD_LEN-1:0][DIGIT_W-1:0] digits_mem [ENTRIES];
   logic [LEN_W-1:0]                 len_mem    [ENTRIES];

   logic [WORD_LEN-1:0][DIGIT_W-1:0] rd_digits_ff;
   logic [LEN_W-1:0]                 rd_len_ff;

   // one digit of a row is written per load item
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digits_mem[wr_addr][wr_pos] <= wr_digit;
      end
      if (len_en) begin
         len_mem[wr_addr] <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_digits_ff <= digits_mem[rd_addr];
         rd_len_ff    <= len_mem[rd_addr];
      end
   end

   assign rd_digits = rd_digits_ff;
   assign rd_len    = rd_len_ff;

endmodule

[rtl/kpd_match.sv]
// prefix compare stage: checks one stored row against the query digits
// registers the outcome with its entry tag; uses kpd_pkg
`timescale 1ns / 1ps

module kpd_match #(
   parameter int WORD_LEN = kpd_pkg::DEFAULT_WORD_LEN,
   localparam int LEN_W   = $clog2(WORD_LEN + 1)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  kpd_pkg::scan_tag_type                      tag,
   input  logic [WORD_LEN-1:0][kpd_pkg::DIGIT_W-1:0]  row_digits,
   input  logic [LEN_W-1:0]                           row_len,
   input  logic [WORD_LEN-1:0][kpd_pkg::DIGIT_W-1:0]  query_digits,
   input  logic [LEN_W-1:0]                           query_len,
   output kpd_pkg::match_type                         match
);
   import kpd_pkg::*;

   logic      digits_equal;
   logic      hit;
   match_type match_ff;
   match_type match_in;

   // only positions below the query length take part
   always_comb begin
      digits_equal = 1'b1;
      for (int i = 0; i < WORD_LEN; i++) begin
         if (LEN_W'(i) < query_len && row_digits[i] != query_digits[i]) begin
            digits_equal = 1'b0;
         end
      end
   end

   assign hit = (row_len >= query_len) && digits_equal;

   always_comb begin
      match_in.valid = tag.valid;
      match_in.last  = tag.last;
      match_in.hit   = tag.valid && hit;
      match_in.entry = tag.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match = match_ff;

endmodule

[rtl/keypad_code_prefix_dictionary.sv]
// top level of the keypad code prefix dictionary: item control, scan sequencer,
// result register; uses kpd_pkg, kpd_code_mem and kpd_match
`timescale 1ns / 1ps

// Usage
// An item is taken at a clock edge where start is high and busy is low. A load
// item (req_command 0) gives one character of a word, a query item
// (req_command 1) one keypad digit; req_last marks the final one of each.
// Items without req_last give no result and do not raise busy, so loads and
// query digits can arrive back to back.
// A final load item gives one result with rsp_valid high in the next cycle:
// the slot the word went to, or a full / word-too-long status.
// A final query digit raises busy while the scan sequencer reads the stored
// codes from the code memory, one entry per cycle over its single read port.
// Matches come out in ascending entry order, at most one per cycle, each
// result in the cycle after the next match is seen; the last is marked by
// rsp_last_result. A query with no stored words or an overlong one answers in
// the next cycle. Otherwise a final query keeps busy high from acceptance
// through the S_SCAN, S_DRAIN and S_FINAL states.
// Each result is on the rsp_ ports for exactly one cycle; the receiver cannot
// stall it. Reset empties the dictionary and drops any partial word or query;
// the code memory needs no clearing since only committed entries are read.

module keypad_code_prefix_dictionary #(
   parameter int ENTRIES  = kpd_pkg::DEFAULT_ENTRIES,
   parameter int WORD_LEN = kpd_pkg::DEFAULT_WORD_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [kpd_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic [kpd_pkg::MATCH_W-1:0]   rsp_match_index,
   output logic                          rsp_found,
   output logic [kpd_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last_result
);
   import kpd_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int POS_W = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
   localparam int LEN_W = $clog2(WORD_LEN + 1);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_FINAL = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [LEN_W-1:0] load_pos_ff, load_pos_in;
   logic [LEN_W-1:0] query_len_ff, query_len_in;
   logic             overflow_ff, overflow_in;
   logic [WORD_LEN-1:0][DIGIT_W-1:0] query_digits_ff, query_digits_in;
   logic [CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [MATCH_W-1:0] pend_entry_ff, pend_entry_in;
   scan_tag_type     tag_ff, tag_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MATCH_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic             take;
   logic             ovf_next;
   logic [LEN_W-1:0] pos_next;
   logic             mem_wr_en;
   logic             mem_len_en;
   logic [WORD_LEN-1:0][DIGIT_W-1:0] row_digits;
   logic [LEN_W-1:0] row_len;
   match_type        match;

   assign busy = (state_ff != S_IDLE);
   assign take = start && !busy;

   kpd_code_mem #(
      .ENTRIES  (ENTRIES),
      .WORD_LEN (WORD_LEN)
   ) u_code_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (entry_count_ff[IDX_W-1:0]),
      .wr_pos    (load_pos_ff[POS_W-1:0]),
      .wr_digit  (key_of(req_symbol)),
      .len_en    (mem_len_en),
      .wr_len    (pos_next),
      .rd_en     (tag_in.valid),
      .rd_addr   (scan_addr_ff[IDX_W-1:0]),
      .rd_digits (row_digits),
      .rd_len    (row_len)
   );

   kpd_match #(
      .WORD_LEN (WORD_LEN)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .tag          (tag_ff),
      .row_digits   (row_digits),
      .row_len      (row_len),
      .query_digits (query_digits_ff),
      .query_len    (query_len_ff),
      .match        (match)
   );

   always_comb begin
      state_in        = state_ff;
      entry_count_in  = entry_count_ff;
      load_pos_in     = load_pos_ff;
      query_len_in    = query_len_ff;
      overflow_in     = overflow_ff;
      query_digits_in = query_digits_ff;
      scan_addr_in    = scan_addr_ff;
      pend_valid_in   = pend_valid_ff;
      pend_entry_in   = pend_entry_ff;
      tag_in          = '0;
      rsp_valid_in    = 1'b0;
      rsp_index_in    = rsp_index_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      ovf_next        = overflow_ff;
      pos_next        = load_pos_ff;
      mem_wr_en       = 1'b0;
      mem_len_en      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (take && req_command == CMD_LOAD) begin
               // a load abandons any partly entered query
               ovf_next     = (query_len_ff != '0) ? 1'b0 : overflow_ff;
               query_len_in = '0;
               if (load_pos_ff < LEN_W'(WORD_LEN)) begin
                  mem_wr_en = (entry_count_ff < CNT_W'(ENTRIES));
                  pos_next  = LEN_W'(load_pos_ff + 1'b1);
               end else begin
                  ovf_next = 1'b1;
               end
               load_pos_in = pos_next;
               overflow_in = ovf_next;
               if (req_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_index_in  = '0;
                  rsp_found_in  = 1'b0;
                  rsp_status_in = STATUS_OK;
                  if (entry_count_ff >= CNT_W'(ENTRIES)) begin
                     rsp_status_in = STATUS_FULL;
                  end else if (ovf_next) begin
                     rsp_status_in = STATUS_WORD_LONG;
                  end else begin
                     mem_len_en     = 1'b1;
                     rsp_found_in   = 1'b1;
                     rsp_index_in   = MATCH_W'(entry_count_ff);
                     entry_count_in = CNT_W'(entry_count_ff + 1'b1);
                  end
                  load_pos_in = '0;
                  overflow_in = 1'b0;
               end
            end else if (take) begin
               // a query abandons any partly loaded word
               ovf_next    = (load_pos_ff != '0) ? 1'b0 : overflow_ff;
               load_pos_in = '0;
               pos_next    = query_len_ff;
               if (query_len_ff < LEN_W'(WORD_LEN)) begin
                  query_digits_in[query_len_ff[POS_W-1:0]] = query_digit(req_symbol);
                  pos_next = LEN_W'(query_len_ff + 1'b1);
               end else begin
                  ovf_next = 1'b1;
               end
               query_len_in = pos_next;
               overflow_in  = ovf_next;
               if (req_last) begin
                  if (ovf_next || entry_count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_last_in   = 1'b1;
                     rsp_index_in  = '0;
                     rsp_found_in  = 1'b0;
                     rsp_status_in = ovf_next ? STATUS_QUERY_LONG : STATUS_OK;
                     query_len_in  = '0;
                     overflow_in   = 1'b0;
                  end else begin
                     state_in      = S_SCAN;
                     scan_addr_in  = '0;
                     pend_valid_in = 1'b0;
                  end
               end
            end
         end
         S_SCAN: begin
            tag_in.valid = 1'b1;
            tag_in.entry = MATCH_W'(scan_addr_ff);
            tag_in.last  = (CNT_W'(scan_addr_ff + 1'b1) == entry_count_ff);
            scan_addr_in = CNT_W'(scan_addr_ff + 1'b1);
            if (tag_in.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // wait for the last compare to come back
         end
         S_FINAL: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_found_in  = pend_valid_ff;
            rsp_index_in  = pend_valid_ff ? pend_entry_ff : '0;
            query_len_in  = '0;
            overflow_in   = 1'b0;
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a match is held back until the next one shows it was not the last
      if (match.valid) begin
         if (match.hit) begin
            if (pend_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b0;
               rsp_found_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = pend_entry_ff;
            end
            pend_valid_in = 1'b1;
            pend_entry_in = match.entry;
         end
         if (match.last) begin
            state_in = S_FINAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         load_pos_ff    <= '0;
         query_len_ff   <= '0;
         overflow_ff    <= 1'b0;
         scan_addr_ff   <= '0;
         pend_valid_ff  <= 1'b0;
         tag_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         load_pos_ff    <= load_pos_in;
         query_len_ff   <= query_len_in;
         overflow_ff    <= overflow_in;
         scan_addr_ff   <= scan_addr_in;
         pend_valid_ff  <= pend_valid_in;
         tag_ff         <= tag_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_digits_ff <= query_digits_in;
      pend_entry_ff   <= pend_entry_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond dictionary size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> scan_addr_ff <= entry_count_ff)
      else $error("scan address past stored entries");

   a_idle_result_from_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && $past(state_ff == S_IDLE)) |-> $past(take))
      else $error("result out of idle without an accepted item");

   a_final_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("final result while still scanning");

   a_partial_result_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> busy)
      else $error("non-final result outside a scan");

   a_match_only_busy: assert property (@(posedge clock) disable iff (reset)
      match.valid |-> (state_ff == S_SCAN || state_ff == S_DRAIN))
      else $error("compare result outside a scan");

endmodule
